// ----- design/bcr_pkg.sv -----
// Package for the x86 branch classifier and re-encoder.
// Holds opcode codes, encoding lengths and the decode word passed between stages.
// Has no dependencies.
package bcr_pkg;

	localparam int ADDRESS_BITS_DEFAULT = 32;

	// Opcode bytes.
	localparam logic [7:0] OP_CALL_REL    = 8'hE8;
	localparam logic [7:0] OP_CALL_FAR    = 8'h9A;
	localparam logic [7:0] OP_GRP5        = 8'hFF;
	localparam logic [7:0] OP_RET_NEAR_IV = 8'hC2;
	localparam logic [7:0] OP_RET_NEAR    = 8'hC3;
	localparam logic [7:0] OP_RET_FAR_IV  = 8'hCA;
	localparam logic [7:0] OP_RET_FAR     = 8'hCB;
	localparam logic [7:0] OP_IRET        = 8'hCF;
	localparam logic [7:0] OP_JCC_SHORT_LO = 8'h70;
	localparam logic [7:0] OP_JCC_SHORT_HI = 8'h7F;
	localparam logic [7:0] OP_LOOP_LO     = 8'hE0;
	localparam logic [7:0] OP_LOOP_HI     = 8'hE3;
	localparam logic [7:0] OP_ESCAPE      = 8'h0F;
	localparam logic [7:0] OP_JMP_SHORT   = 8'hEB;
	localparam logic [7:0] OP_JMP_NEAR    = 8'hE9;
	localparam logic [7:0] OP_JMP_FAR     = 8'hEA;
	localparam logic [7:0] OP_JCC_NEAR_LO = 8'h80;
	localparam logic [7:0] OP_JCC_NEAR_HI = 8'h8F;
	localparam logic [7:0] CC_NEAR_DELTA  = 8'h10;

	// ModRM reg codes of the FF group that branch.
	localparam logic [2:0] GRP5_CALL  = 3'd2;
	localparam logic [2:0] GRP5_CALLF = 3'd3;
	localparam logic [2:0] GRP5_JMP   = 3'd4;
	localparam logic [2:0] GRP5_JMPF  = 3'd5;

	// Immediate sizes in bytes.
	localparam logic [2:0] IMM_BYTE  = 3'd1;
	localparam logic [2:0] IMM_WORD  = 3'd2;
	localparam logic [2:0] IMM_DWORD = 3'd4;

	// Encoded lengths.
	localparam logic [2:0] LEN_NONE    = 3'd0;
	localparam logic [2:0] LEN_SHORT   = 3'd2;
	localparam logic [2:0] LEN_NEAR    = 3'd5;
	localparam logic [2:0] LEN_NEAR_CC = 3'd6;

	typedef struct packed {
		logic       call;
		logic       ret;
		logic       cond;
		logic       uncond;
		logic       short_cc;
		logic       near_cc;
		logic       jmp_rel;
		logic       tgt_en;
		logic       fits;
		logic [7:0] op_first;
		logic [7:0] op_second;
	} dec_t;

endpackage

// ----- design/bcr_decode.sv -----
// First stage: classifies the opcode, sign-extends the immediate, checks whether
// the new offset fits a byte and takes the instruction length. Depends on bcr_pkg.
module bcr_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        opcode_first,
	input  logic [7:0]        opcode_second,
	input  logic [2:0]        modrm_reg,
	input  logic [2:0]        imm_size,
	input  logic signed [31:0] imm_value,
	input  logic [31:0]       start_address,
	input  logic [31:0]       end_address,
	input  logic signed [31:0] jump_offset,
	output logic              vld_s1,
	output bcr_pkg::dec_t     dec_s1,
	output logic [31:0]       imm_s1,
	output logic [31:0]       end_s1,
	output logic [31:0]       noff_s1,
	output logic [7:0]        ilen_s1
);
	import bcr_pkg::*;

	dec_t        dec;
	logic [31:0] imm_ext;
	logic        size_ok;
	logic        loop_j;
	logic [7:0]  end_lo;
	logic [7:0]  start_lo;

	always_comb begin
		dec.op_first  = opcode_first;
		dec.op_second = opcode_second;
		dec.call = (opcode_first == OP_CALL_REL) || (opcode_first == OP_CALL_FAR) ||
			((opcode_first == OP_GRP5) &&
			 ((modrm_reg == GRP5_CALL) || (modrm_reg == GRP5_CALLF)));
		dec.ret = (opcode_first == OP_RET_NEAR_IV) || (opcode_first == OP_RET_NEAR) ||
			(opcode_first == OP_RET_FAR_IV) || (opcode_first == OP_RET_FAR) ||
			(opcode_first == OP_IRET);
		dec.near_cc = (opcode_first == OP_ESCAPE) && (opcode_second >= OP_JCC_NEAR_LO) &&
			(opcode_second <= OP_JCC_NEAR_HI);
		dec.short_cc = (opcode_first >= OP_JCC_SHORT_LO) &&
			(opcode_first <= OP_JCC_SHORT_HI);
		loop_j = (opcode_first >= OP_LOOP_LO) && (opcode_first <= OP_LOOP_HI);
		dec.cond = dec.short_cc || loop_j || dec.near_cc;
		dec.jmp_rel = (opcode_first == OP_JMP_SHORT) || (opcode_first == OP_JMP_NEAR);
		dec.uncond = dec.jmp_rel || (opcode_first == OP_JMP_FAR) ||
			((opcode_first == OP_GRP5) &&
			 ((modrm_reg == GRP5_JMP) || (modrm_reg == GRP5_JMPF)));

		imm_ext = '0;
		size_ok = 1'b0;
		case (imm_size)
			IMM_BYTE: begin
				imm_ext = {{24{imm_value[7]}}, imm_value[7:0]};
				size_ok = 1'b1;
			end
			IMM_WORD: begin
				imm_ext = {{16{imm_value[15]}}, imm_value[15:0]};
				size_ok = 1'b1;
			end
			IMM_DWORD: begin
				imm_ext = imm_value;
				size_ok = 1'b1;
			end
			default: begin
				imm_ext = '0;
				size_ok = 1'b0;
			end
		endcase

		// A direct call takes only a word or dword immediate.
		dec.tgt_en = ((opcode_first == OP_CALL_REL) && size_ok && (imm_size != IMM_BYTE)) ||
			((dec.cond || dec.jmp_rel) && size_ok);

		// The offset fits a signed byte when its top 25 bits all agree.
		dec.fits = (jump_offset[31:7] == '0) || (jump_offset[31:7] == '1);

		end_lo   = end_address[7:0];
		start_lo = start_address[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			dec_s1  <= dec;
			imm_s1  <= imm_ext;
			end_s1  <= end_address;
			noff_s1 <= jump_offset;
			ilen_s1 <= end_lo - start_lo;
		end
	end

endmodule

// ----- design/bcr_target.sv -----
// Second stage branch target adder: end address plus immediate, wrapped to
// the address width. Depends on bcr_pkg.
module bcr_target #(
	parameter int ADDRESS_BITS = bcr_pkg::ADDRESS_BITS_DEFAULT
) (
	input  logic          clk,
	input  logic          vld_s1,
	input  bcr_pkg::dec_t dec_s1,
	input  logic [31:0]   imm_s1,
	input  logic [31:0]   end_s1,
	output logic [31:0]   tgt_s2,
	output logic          tgt_valid_s2
);
	import bcr_pkg::*;

	// Addresses wider than the 32-bit ports wrap at bit 32.
	localparam int SUM_BITS = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;

	logic [SUM_BITS-1:0] sum;

	assign sum = end_s1[SUM_BITS-1:0] + imm_s1[SUM_BITS-1:0];

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			tgt_valid_s2 <= dec_s1.tgt_en;
			tgt_s2       <= dec_s1.tgt_en ? 32'(sum) : 32'd0;
		end
	end

endmodule

// ----- design/bcr_encode.sv -----
// Second stage jump re-encoder: picks the short or near form and lays out
// the bytes, first byte lowest. Depends on bcr_pkg.
module bcr_encode (
	input  logic          clk,
	input  logic          vld_s1,
	input  bcr_pkg::dec_t dec_s1,
	input  logic [31:0]   noff_s1,
	output logic [47:0]   enc_s2,
	output logic [2:0]    len_s2
);
	import bcr_pkg::*;

	logic [47:0] enc;
	logic [2:0]  len;
	logic [7:0]  b8;

	always_comb begin
		b8  = noff_s1[7:0];
		enc = '0;
		len = LEN_NONE;
		// Loop jumps fall through every arm and stay unwritten.
		if (dec_s1.fits) begin
			if (dec_s1.short_cc || (dec_s1.op_first == OP_JMP_SHORT)) begin
				enc = 48'({b8, dec_s1.op_first});
				len = LEN_SHORT;
			end else if (dec_s1.op_first == OP_JMP_NEAR) begin
				enc = 48'({b8, OP_JMP_SHORT});
				len = LEN_SHORT;
			end else if (dec_s1.near_cc) begin
				enc = 48'({b8, dec_s1.op_second - CC_NEAR_DELTA});
				len = LEN_SHORT;
			end
		end else begin
			if (dec_s1.short_cc) begin
				enc = {noff_s1, dec_s1.op_first + CC_NEAR_DELTA, OP_ESCAPE};
				len = LEN_NEAR_CC;
			end else if (dec_s1.jmp_rel) begin
				enc = 48'({noff_s1, OP_JMP_NEAR});
				len = LEN_NEAR;
			end else if (dec_s1.near_cc) begin
				enc = {noff_s1, dec_s1.op_second, OP_ESCAPE};
				len = LEN_NEAR_CC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			enc_s2 <= enc;
			len_s2 <= len;
		end
	end

endmodule

// ----- design/x86_branch_classify_and_reencode.sv -----
// Top level of the x86 branch classifier and jump re-encoder.
// Depends on bcr_pkg, bcr_decode, bcr_target and bcr_encode.
//
// Usage: drive the decoded instruction fields and raise start for one cycle
// per instruction. busy is always low, so a word is taken at every cycle in
// which start is high; a new instruction may follow in every cycle.
// The word passes three register stages: decode, then target add and
// re-encode, then the output register. done is the valid bit of the
// output register, fed from the stage-two valid bit, and is high for a
// single cycle per result; the receiver must take it then, as it
// cannot stall.
// Throughput is one instruction per cycle, since no stage ever holds a
// word back.
// Results leave in the order the instructions came in.
// Reset clears the stage valid bits, so nothing in flight survives it and
// done stays low until a new word has crossed all three stages.
module x86_branch_classify_and_reencode #(
	parameter int ADDRESS_BITS = bcr_pkg::ADDRESS_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         opcode_first,
	input  logic [7:0]         opcode_second,
	input  logic [2:0]         modrm_reg,
	input  logic [2:0]         imm_size,
	input  logic signed [31:0] imm_value,
	input  logic [31:0]        start_address,
	input  logic [31:0]        end_address,
	input  logic signed [31:0] jump_offset,
	output logic               done,
	output logic               call_flag,
	output logic               return_flag,
	output logic               cond_jump_flag,
	output logic               uncond_jump_flag,
	output logic [31:0]        target_address,
	output logic               target_valid,
	output logic [47:0]        encoded_bytes,
	output logic [2:0]         encoded_length,
	output logic [7:0]         instruction_length
);
	import bcr_pkg::*;

	logic        vld_s1;
	dec_t        dec_s1;
	logic [31:0] imm_s1;
	logic [31:0] end_s1;
	logic [31:0] noff_s1;
	logic [7:0]  ilen_s1;

	logic        vld_s2;
	logic [3:0]  flags_s2;
	logic [7:0]  ilen_s2;
	logic [31:0] tgt_s2;
	logic        tgt_valid_s2;
	logic [47:0] enc_s2;
	logic [2:0]  len_s2;

	assign busy = 1'b0;

	bcr_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start && !busy),
		.opcode_first  (opcode_first),
		.opcode_second (opcode_second),
		.modrm_reg     (modrm_reg),
		.imm_size      (imm_size),
		.imm_value     (imm_value),
		.start_address (start_address),
		.end_address   (end_address),
		.jump_offset   (jump_offset),
		.vld_s1        (vld_s1),
		.dec_s1        (dec_s1),
		.imm_s1        (imm_s1),
		.end_s1        (end_s1),
		.noff_s1       (noff_s1),
		.ilen_s1       (ilen_s1)
	);

	bcr_target #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_target (
		.clk          (clk),
		.vld_s1       (vld_s1),
		.dec_s1       (dec_s1),
		.imm_s1       (imm_s1),
		.end_s1       (end_s1),
		.tgt_s2       (tgt_s2),
		.tgt_valid_s2 (tgt_valid_s2)
	);

	bcr_encode u_encode (
		.clk     (clk),
		.vld_s1  (vld_s1),
		.dec_s1  (dec_s1),
		.noff_s1 (noff_s1),
		.enc_s2  (enc_s2),
		.len_s2  (len_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			done   <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			flags_s2 <= {dec_s1.call, dec_s1.ret, dec_s1.cond, dec_s1.uncond};
			ilen_s2  <= ilen_s1;
		end
		if (vld_s2) begin
			{call_flag, return_flag, cond_jump_flag, uncond_jump_flag} <= flags_s2;
			target_address     <= tgt_s2;
			target_valid       <= tgt_valid_s2;
			encoded_bytes      <= enc_s2;
			encoded_length     <= len_s2;
			instruction_length <= ilen_s2;
		end
	end

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |=> done)
		else $error("stage two word did not reach the output");

	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (encoded_length == LEN_NONE) || (encoded_length == LEN_SHORT) ||
			(encoded_length == LEN_NEAR) || (encoded_length == LEN_NEAR_CC))
		else $error("illegal encoded length");

	a_enc_is_jump: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (encoded_length != LEN_NONE)) |-> (cond_jump_flag || uncond_jump_flag))
		else $error("re-encoded word is not a jump");

	a_tgt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !target_valid) |-> (target_address == 32'd0))
		else $error("target address set without a valid target");

endmodule
